// ===== sv/btda_pkg.sv =====
package btda_pkg;
  localparam int MAX_EXTENTS_DEF = 16;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd2;

  localparam logic [1:0] CFG_BPT = 2'd0;
  localparam logic [1:0] CFG_DEV = 2'd1;
  localparam logic [1:0] CFG_CNT = 2'd2;

  typedef struct packed {
    logic [15:0] bin;
    logic [15:0] start_cyl;
    logic [15:0] start_track;
    logic [15:0] tracks;
  } extent_t;

  // record travelling down the extent chain
  typedef struct packed {
    logic        busy;
    logic        found;
    logic [7:0]  ext;
    logic [31:0] track;
    logic [15:0] bin;
    logic [15:0] cyl;
    logic [16:0] hh;
  } walk_t;

  function automatic logic [4:0] tracks_per_cyl(input logic [3:0] dev);
    logic [4:0] t;
    begin
      case (dev)
        4'd1:  t = 5'd10;
        4'd6:  t = 5'd8;
        4'd7:  t = 5'd8;
        4'd8:  t = 5'd20;
        4'd9:  t = 5'd19;
        4'd10: t = 5'd12;
        4'd11: t = 5'd30;
        4'd12: t = 5'd12;
        4'd13: t = 5'd19;
        4'd14: t = 5'd15;
        4'd15: t = 5'd15;
        default: t = 5'd0;
      endcase
      return t;
    end
  endfunction
endpackage

// ===== sv/btda_cell.sv =====
// One extent: holds its entry and tests the walk record passing through.
module btda_cell import btda_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    ld,
  input  extent_t ld_ent,
  input  logic    active,
  input  walk_t   w_in,
  output walk_t   w_out
);
  extent_t ent_r;
  walk_t   w_r, w_nxt;

  always_ff @(posedge clk) begin
    if (ld) ent_r <= ld_ent;
  end

  always_comb begin
    w_nxt = w_in;
    if (w_in.busy && !w_in.found && active) begin
      if (w_in.track < {16'd0, ent_r.tracks}) begin
        w_nxt.found = 1'b1;
        w_nxt.ext   = 8'(IDX);
        w_nxt.bin   = ent_r.bin;
        w_nxt.cyl   = ent_r.start_cyl;
        w_nxt.hh    = {1'b0, ent_r.start_track} + w_in.track[16:0];
      end else begin
        w_nxt.track = w_in.track - {16'd0, ent_r.tracks};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) w_r.busy <= 1'b0;
    else        w_r.busy <= w_nxt.busy;
    w_r.found <= w_nxt.found;
    w_r.ext   <= w_nxt.ext;
    w_r.track <= w_nxt.track;
    w_r.bin   <= w_nxt.bin;
    w_r.cyl   <= w_nxt.cyl;
    w_r.hh    <= w_nxt.hh;
  end
  assign w_out = w_r;
endmodule

// ===== sv/block_to_disk_address.sv =====
// Channel | Direction | Transaction
// in_     | input     | load extent or convert block number
// out_    | output    | one address result per convert
// cfg_    | input     | register write (index, data)
// A convert divides the block number by blocks per track (restoring division), passes a
// walk record through the extent chain and divides the track sum by tracks per cylinder
// for the cylinder carry (no division with zero blocks per track, none of these steps for
// an unsupported device). A load writes its extent cell on acceptance. One item is in
// work at a time; in_ready is low meanwhile and returns in the cycle after the result is
// taken. A stalled result holds in the output register and blocks the next item.
// Reset (synchronous) clears control state and configuration; the extent table is not cleared.
module block_to_disk_address import btda_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_extent_index,
  input  logic [15:0] in_extent_bin,
  input  logic [15:0] in_extent_start_cyl,
  input  logic [15:0] in_extent_start_track,
  input  logic [15:0] in_extent_tracks,
  input  logic [31:0] in_block_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_extent_number,
  output logic [15:0] out_bin_number,
  output logic [15:0] out_cylinder,
  output logic [15:0] out_head_track,
  output logic [7:0]  out_record_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_CARRY = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [7:0] bpt_r;
  logic [3:0] dev_r;
  logic [4:0] cnt_r;
  logic [2:0] st_r;
  logic [5:0] k_r;
  logic [31:0] q_r;
  logic [7:0]  rem_r;
  logic [7:0]  rec_r;
  walk_t       wl_r;
  logic [16:0] hh_r;
  logic [4:0]  hr_r;
  logic [15:0] cyl_r;
  logic [4:0]  tpc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == S_IDLE);
  assign tpc       = tracks_per_cyl(dev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpt_r <= '0; dev_r <= '0; cnt_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BPT: bpt_r <= cfg_data;
        CFG_DEV: dev_r <= cfg_data[3:0];
        CFG_CNT: cnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective extent count, clamped to the table depth
  logic [CW-1:0] eff_cnt;
  always_comb begin
    if ({27'd0, cnt_r} > 32'(MAX_EXTENTS)) eff_cnt = CW'(MAX_EXTENTS);
    else eff_cnt = CW'(cnt_r);
  end

  // extent chain
  walk_t  w [MAX_EXTENTS+1];
  extent_t ld_ent;
  logic   acc;
  assign acc = in_valid && in_ready;
  assign ld_ent = '{in_extent_bin, in_extent_start_cyl, in_extent_start_track,
                    in_extent_tracks};
  assign w[0] = wl_r;

  for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
    btda_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .ld(acc && (in_action == ACT_LOAD) && ({28'd0, in_extent_index} == 32'(g))),
      .ld_ent(ld_ent),
      .active(CW'(g) < eff_cnt),
      .w_in(w[g]), .w_out(w[g+1])
    );
  end

  // block number divider step
  logic [8:0] trial;
  assign trial = {rem_r, q_r[31]} - {1'b0, bpt_r};

  // cylinder carry divider step
  logic [5:0] ctrial;
  assign ctrial = {hr_r, hh_r[16]} - {1'b0, tpc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0; wl_r.busy <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (acc && (in_action == ACT_CONVERT)) begin
          q_r <= in_block_number; rem_r <= '0; k_r <= '0;
          if (tpc == 5'd0) begin
            out_status <= ST_UNSUPPORTED; out_extent_number <= '0;
            out_bin_number <= '0; out_cylinder <= '0; out_head_track <= '0;
            out_record_number <= '0; out_valid <= 1'b1; st_r <= S_OUT;
          end else st_r <= S_DIV;
        end
        S_DIV: begin
          if (bpt_r == 8'd0) begin
            rec_r <= 8'd1;
            wl_r <= '{1'b1, 1'b0, 8'd0, 32'd0, 16'd0, 16'd0, 17'd0};
            k_r <= '0; st_r <= S_WALK;
          end else begin
            if (!trial[8]) begin
              rem_r <= trial[7:0]; q_r <= {q_r[30:0], 1'b1};
            end else begin
              rem_r <= {rem_r[6:0], q_r[31]}; q_r <= {q_r[30:0], 1'b0};
            end
            k_r <= k_r + 6'd1;
            if (k_r == 6'd31) begin
              rec_r <= trial[8] ? {rem_r[6:0], q_r[31]} : trial[7:0];
              st_r <= S_WALK; k_r <= '0;
            end
          end
        end
        S_WALK: begin
          // launch pulse lasts one cycle
          if (wl_r.busy) wl_r.busy <= 1'b0;
          else if (k_r == 6'd0) begin
            if (bpt_r != 8'd0) begin
              rec_r <= rec_r + 8'd1;
              wl_r <= '{1'b1, 1'b0, 8'd0, q_r, 16'd0, 16'd0, 17'd0};
            end
            k_r <= 6'd1;
          end
          if (w[MAX_EXTENTS].busy) begin
            if (w[MAX_EXTENTS].found) begin
              hh_r <= w[MAX_EXTENTS].hh; cyl_r <= w[MAX_EXTENTS].cyl;
              hr_r <= '0; k_r <= '0;
              out_extent_number <= w[MAX_EXTENTS].ext[3:0];
              out_bin_number <= w[MAX_EXTENTS].bin;
              out_record_number <= rec_r; st_r <= S_CARRY;
            end else begin
              out_status <= ST_NOT_FOUND; out_extent_number <= '0;
              out_bin_number <= '0; out_cylinder <= '0; out_head_track <= '0;
              out_record_number <= '0; out_valid <= 1'b1; st_r <= S_OUT;
            end
          end
        end
        S_CARRY: begin
          // restoring division of the track sum by tracks per cylinder, 17 steps
          if (!ctrial[5]) begin
            hr_r <= ctrial[4:0]; hh_r <= {hh_r[15:0], 1'b1};
          end else begin
            hr_r <= {hr_r[3:0], hh_r[16]}; hh_r <= {hh_r[15:0], 1'b0};
          end
          k_r <= k_r + 6'd1;
          if (k_r == 6'd16) begin
            out_status <= ST_OK;
            out_cylinder <= cyl_r + {hh_r[14:0], ~ctrial[5]};
            out_head_track <= {11'd0, (ctrial[5] ? {hr_r[3:0], hh_r[16]} : ctrial[4:0])};
            out_valid <= 1'b1; st_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
